// File: design/three_wire_serial_register_master_macros.svh
// assertion macros used by the checker file
`ifndef THREE_WIRE_SERIAL_REGISTER_MASTER_MACROS_SVH
`define THREE_WIRE_SERIAL_REGISTER_MASTER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TWS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tws checker: same-cycle property failed");

// next-cycle implication, checked on every rising edge outside reset
`define TWS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tws checker: next-cycle property failed");

`endif

// File: design/tws_pkg.sv
package tws_pkg;

   // request codes carried by req_type
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2
   } req_code_type;

   // frame layout in waveform slots
   localparam int PREAMBLE_SLOTS = 2;   // select low, clock high
   localparam int SELECT_SLOTS   = 4;   // end of the select preamble
   localparam int HEAD_SLOTS     = 6;   // preamble plus direction bit
   localparam int TRAILER_SLOTS  = 2;   // write trailer or read turnaround

   localparam int SLOT_TICKS_WIDTH = 16;
   localparam logic [SLOT_TICKS_WIDTH-1:0] SLOT_TICKS_RESET = 16'd10;

   // pin levels and status of one result
   typedef struct packed {
      logic chip_select;
      logic serial_clock;
      logic serial_out;
      logic busy;
      logic done;
      logic rejected;
   } pins_type;

endpackage

// File: design/tws_input_stage.sv
module tws_input_stage #(
   parameter int ADDRESS_BITS = 5,
   parameter int DATA_BITS    = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    req_valid,
   input  logic [1:0]              req_type,
   input  logic [ADDRESS_BITS-1:0] req_reg_address,
   input  logic [DATA_BITS-1:0]    req_write_data,
   input  logic                    req_serial_in,
   output logic                    stage_valid,
   output logic [1:0]              stage_type,
   output logic [ADDRESS_BITS-1:0] stage_reg_address,
   output logic [DATA_BITS-1:0]    stage_write_data,
   output logic                    stage_serial_in
);

   logic                    valid_ff;
   logic [1:0]              type_ff;
   logic [ADDRESS_BITS-1:0] address_ff;
   logic [DATA_BITS-1:0]    data_ff;
   logic                    serial_in_ff;

   // request valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_valid;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (advance) begin
         type_ff      <= req_type;
         address_ff   <= req_reg_address;
         data_ff      <= req_write_data;
         serial_in_ff <= req_serial_in;
      end
   end

   assign stage_valid       = valid_ff;
   assign stage_type        = type_ff;
   assign stage_reg_address = address_ff;
   assign stage_write_data  = data_ff;
   assign stage_serial_in   = serial_in_ff;

endmodule

// File: design/tws_frame_engine.sv
module tws_frame_engine #(
   parameter int ADDRESS_BITS = 5,
   parameter int DATA_BITS    = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  logic                                 csr_write_enable,
   input  logic [tws_pkg::SLOT_TICKS_WIDTH-1:0] csr_write_data,
   input  logic [1:0]                           req_type,
   input  logic [ADDRESS_BITS-1:0]              req_reg_address,
   input  logic [DATA_BITS-1:0]                 req_write_data,
   input  logic                                 req_serial_in,
   output tws_pkg::pins_type                    pins,
   output logic [DATA_BITS-1:0]                 read_data
);

   localparam int WORD_BITS   = ADDRESS_BITS + DATA_BITS;
   localparam int TOTAL_SLOTS = tws_pkg::HEAD_SLOTS + 2 * ADDRESS_BITS + 2 * DATA_BITS
                                + tws_pkg::TRAILER_SLOTS;
   localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
   localparam int POS_W       = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   // first low slot after the turnaround clock
   localparam int RD_START    = tws_pkg::HEAD_SLOTS + 2 * ADDRESS_BITS
                                + tws_pkg::TRAILER_SLOTS;
   localparam int TW          = tws_pkg::SLOT_TICKS_WIDTH;

   logic [TW-1:0]        slot_ticks_ff;
   logic [SLOT_W-1:0]    slot_index_ff, slot_index_in;
   logic [TW-1:0]        tick_count_ff, tick_count_in;
   logic [WORD_BITS-1:0] transmit_shift_ff, transmit_shift_in;
   logic [DATA_BITS-1:0] receive_shift_ff, receive_shift_in;
   logic                 read_mode_ff, read_mode_in;
   logic                 frame_active_ff, frame_active_in;
   logic [DATA_BITS-1:0] read_result_ff, read_result_in;

   logic                 is_req, start, rejected;
   logic                 act_e, rm_e;
   logic [SLOT_W-1:0]    s_e;
   logic [TW-1:0]        tick_e, tick_inc, slot_len;
   logic [WORD_BITS-1:0] tx_e;
   logic                 slot_end, last_slot, sample, done;
   logic [SLOT_W:0]      s_inc;
   logic [DATA_BITS:0]   rx_shifted;
   logic [DATA_BITS-1:0] rx_e_next;
   logic [SLOT_W-1:0]    k_raw, k_lim, k_sel, pos;
   logic                 word_level, data_level;

   // request decode and the state the tick works on
   always_comb begin
      is_req   = (req_type == tws_pkg::REQ_WRITE) || (req_type == tws_pkg::REQ_READ);
      start    = is_req && !frame_active_ff;
      rejected = is_req && frame_active_ff;
      act_e    = frame_active_ff || start;
      s_e      = start ? '0 : slot_index_ff;
      tick_e   = start ? '0 : tick_count_ff;
      rm_e     = start ? (req_type == tws_pkg::REQ_READ) : read_mode_ff;
      if (start) begin
         tx_e = {req_reg_address,
                 (req_type == tws_pkg::REQ_READ) ? {DATA_BITS{1'b0}} : req_write_data};
      end else begin
         tx_e = transmit_shift_ff;
      end
   end

   // slot timing
   always_comb begin
      slot_len  = (slot_ticks_ff == '0) ? TW'(1) : slot_ticks_ff;
      tick_inc  = tick_e + TW'(1);
      slot_end  = act_e && (tick_inc >= slot_len);
      s_inc     = {1'b0, s_e} + (SLOT_W + 1)'(1);
      last_slot = s_inc >= (SLOT_W + 1)'(TOTAL_SLOTS);
      done      = slot_end && last_slot;
   end

   // receive sampling on the last tick of each low slot after the turnaround
   always_comb begin
      sample     = rm_e && (s_e >= SLOT_W'(RD_START)) && !s_e[0];
      rx_shifted = {receive_shift_ff, req_serial_in};
      rx_e_next  = (slot_end && sample) ? rx_shifted[DATA_BITS-1:0] : receive_shift_ff;
   end

   // master data line level, last bit held through read phase and trailer
   always_comb begin
      k_raw = (s_e - SLOT_W'(tws_pkg::HEAD_SLOTS)) >> 1;
      k_lim = rm_e ? SLOT_W'(ADDRESS_BITS - 1) : SLOT_W'(WORD_BITS - 1);
      k_sel = (k_raw > k_lim) ? k_lim : k_raw;
      pos   = SLOT_W'(WORD_BITS - 1) - k_sel;
      word_level = tx_e[pos[POS_W-1:0]];
      if (s_e < SLOT_W'(tws_pkg::SELECT_SLOTS)) begin
         data_level = 1'b1;
      end else if (s_e < SLOT_W'(tws_pkg::HEAD_SLOTS)) begin
         data_level = rm_e;
      end else begin
         data_level = word_level;
      end
   end

   // pin levels and status
   always_comb begin
      pins.rejected = rejected;
      if (act_e) begin
         pins.chip_select  = s_e >= SLOT_W'(tws_pkg::PREAMBLE_SLOTS);
         pins.serial_clock = (s_e < SLOT_W'(tws_pkg::SELECT_SLOTS)) ? 1'b1 : s_e[0];
         pins.serial_out   = data_level;
         pins.busy         = 1'b1;
         pins.done         = done;
      end else begin
         pins.chip_select  = 1'b0;
         pins.serial_clock = 1'b1;
         pins.serial_out   = 1'b0;
         pins.busy         = 1'b0;
         pins.done         = 1'b0;
      end
      read_data = (done && rm_e) ? rx_e_next : read_result_ff;
   end

   // next frame state
   always_comb begin
      frame_active_in   = act_e && !done;
      read_mode_in      = rm_e;
      transmit_shift_in = tx_e;
      receive_shift_in  = rx_e_next;
      read_result_in    = (done && rm_e) ? rx_e_next : read_result_ff;
      if (!act_e) begin
         slot_index_in = slot_index_ff;
         tick_count_in = tick_count_ff;
      end else if (slot_end) begin
         slot_index_in = last_slot ? '0 : s_inc[SLOT_W-1:0];
         tick_count_in = '0;
      end else begin
         slot_index_in = s_e;
         tick_count_in = tick_inc;
      end
   end

   // frame state registers, one update per request
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_index_ff     <= '0;
         tick_count_ff     <= '0;
         transmit_shift_ff <= '0;
         receive_shift_ff  <= '0;
         read_mode_ff      <= 1'b0;
         frame_active_ff   <= 1'b0;
         read_result_ff    <= '0;
      end else if (fire) begin
         slot_index_ff     <= slot_index_in;
         tick_count_ff     <= tick_count_in;
         transmit_shift_ff <= transmit_shift_in;
         receive_shift_ff  <= receive_shift_in;
         read_mode_ff      <= read_mode_in;
         frame_active_ff   <= frame_active_in;
         read_result_ff    <= read_result_in;
      end
   end

   // slot length register
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ticks_ff <= tws_pkg::SLOT_TICKS_RESET;
      end else if (csr_write_enable) begin
         slot_ticks_ff <= csr_write_data;
      end
   end

endmodule

// File: design/tws_output_stage.sv
module tws_output_stage #(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  tws_pkg::pins_type    pins,
   input  logic [DATA_BITS-1:0] read_data,
   input  logic                 rsp_stall,
   output logic                 advance,
   output logic                 rsp_valid,
   output logic                 rsp_chip_select,
   output logic                 rsp_serial_clock,
   output logic                 rsp_serial_out,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic [DATA_BITS-1:0] rsp_read_data,
   output logic                 rsp_rejected
);

   logic                 valid_ff;
   tws_pkg::pins_type    pins_ff;
   logic [DATA_BITS-1:0] read_data_ff;

   // the pipeline moves unless a held result is stalled
   assign advance = !(valid_ff && rsp_stall);

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= load_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         pins_ff      <= pins;
         read_data_ff <= read_data;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_chip_select  = pins_ff.chip_select;
   assign rsp_serial_clock = pins_ff.serial_clock;
   assign rsp_serial_out   = pins_ff.serial_out;
   assign rsp_busy_res     = pins_ff.busy;
   assign rsp_done_res     = pins_ff.done;
   assign rsp_read_data    = read_data_ff;
   assign rsp_rejected     = pins_ff.rejected;

endmodule

// File: design/three_wire_serial_register_master.sv
// Three-wire serial register master. Every request is one tick of the bit timing base and
// may also start a register write (req_type 1) or read (req_type 2); a start while a frame
// runs is dropped and flagged by rsp_rejected. Each slot of the frame lasts csr_write_data
// ticks (reset 10, zero acts as one), so one serial clock period is two slots. Every request
// gives exactly one response with the pin levels for that tick, busy, done and the byte of
// the last read. Requests are taken one per clock with no bubbles while no response
// stalls: each passes an input register, the single-pass frame engine and a result
// register, which offers its response. A stalled response holds the whole pipeline.
module three_wire_serial_register_master #(
   parameter int ADDRESS_BITS = 5,
   parameter int DATA_BITS    = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [tws_pkg::SLOT_TICKS_WIDTH-1:0] csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_type,
   input  logic [ADDRESS_BITS-1:0]              req_reg_address,
   input  logic [DATA_BITS-1:0]                 req_write_data,
   input  logic                                 req_serial_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_chip_select,
   output logic                                 rsp_serial_clock,
   output logic                                 rsp_serial_out,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic [DATA_BITS-1:0]                 rsp_read_data,
   output logic                                 rsp_rejected
);

   logic                    advance;
   logic                    stage_valid;
   logic [1:0]              stage_type;
   logic [ADDRESS_BITS-1:0] stage_reg_address;
   logic [DATA_BITS-1:0]    stage_write_data;
   logic                    stage_serial_in;
   tws_pkg::pins_type       pins;
   logic [DATA_BITS-1:0]    read_data;

   assign req_stall = !advance;

   // input register
   tws_input_stage #(
      .ADDRESS_BITS (ADDRESS_BITS),
      .DATA_BITS    (DATA_BITS)
   ) u_input_stage (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .req_valid         (req_valid),
      .req_type          (req_type),
      .req_reg_address   (req_reg_address),
      .req_write_data    (req_write_data),
      .req_serial_in     (req_serial_in),
      .stage_valid       (stage_valid),
      .stage_type        (stage_type),
      .stage_reg_address (stage_reg_address),
      .stage_write_data  (stage_write_data),
      .stage_serial_in   (stage_serial_in)
   );

   // frame sequencing and pin levels
   tws_frame_engine #(
      .ADDRESS_BITS (ADDRESS_BITS),
      .DATA_BITS    (DATA_BITS)
   ) u_frame_engine (
      .clock            (clock),
      .reset            (reset),
      .fire             (stage_valid && advance),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_type         (stage_type),
      .req_reg_address  (stage_reg_address),
      .req_write_data   (stage_write_data),
      .req_serial_in    (stage_serial_in),
      .pins             (pins),
      .read_data        (read_data)
   );

   // result register
   tws_output_stage #(
      .DATA_BITS (DATA_BITS)
   ) u_output_stage (
      .clock            (clock),
      .reset            (reset),
      .load_valid       (stage_valid),
      .pins             (pins),
      .read_data        (read_data),
      .rsp_stall        (rsp_stall),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_chip_select  (rsp_chip_select),
      .rsp_serial_clock (rsp_serial_clock),
      .rsp_serial_out   (rsp_serial_out),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_data    (rsp_read_data),
      .rsp_rejected     (rsp_rejected)
   );

endmodule

// File: design/tws_checker.sv
`include "three_wire_serial_register_master_macros.svh"

module tws_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_chip_select,
   input logic rsp_serial_clock,
   input logic rsp_serial_out,
   input logic rsp_busy_res,
   input logic rsp_done_res,
   input logic rsp_rejected
);

   logic       idle_levels;
   logic       rsp_held;
   logic [5:0] rsp_levels;

   // idle pin levels, a waiting response and the response bits it must hold
   assign idle_levels = !rsp_chip_select && rsp_serial_clock && !rsp_serial_out;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_levels  = {rsp_chip_select, rsp_serial_clock, rsp_serial_out,
                         rsp_busy_res, rsp_done_res, rsp_rejected};

   // a frame can only finish on a busy tick
   `TWS_ASSERT_IMPLY(a_done_busy, clock, reset, rsp_valid && rsp_done_res, rsp_busy_res)

   // idle ticks drive the idle pin levels
   `TWS_ASSERT_IMPLY(a_idle_pins, clock, reset, rsp_valid && !rsp_busy_res, idle_levels)

   // a rejected request only happens while a frame runs
   `TWS_ASSERT_IMPLY(a_reject_busy, clock, reset, rsp_valid && rsp_rejected, rsp_busy_res)

   // a stalled response holds
   `TWS_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_levels))

endmodule

bind three_wire_serial_register_master tws_checker u_tws_checker (.*);
